// ----- hdl/mss_pkg.sv -----
package mss_pkg;

  localparam longint unsigned MAX_BYTES_DEF = 64'd1048576;
  localparam logic [15:0]     MAX_SITES_RST = 16'hFFFF;
  localparam int              QDEPTH        = 4;
  localparam logic [20:0]     LINE_MAX      = 21'h1FFFFF;

  // replacement operator codes
  localparam logic [2:0] REP_LT  = 3'd0;
  localparam logic [2:0] REP_GT  = 3'd1;
  localparam logic [2:0] REP_NE  = 3'd2;
  localparam logic [2:0] REP_EQ  = 3'd3;
  localparam logic [2:0] REP_OR  = 3'd4;
  localparam logic [2:0] REP_AND = 3'd5;
  localparam logic [2:0] REP_LE  = 3'd6;
  localparam logic [2:0] REP_GE  = 3'd7;

  localparam logic KIND_SITE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // everything one source byte produces: up to two sites and an end record
  typedef struct packed {
    logic [1:0]  n_sites;
    logic        has_end;
    logic [19:0] off0;
    logic [1:0]  len0;
    logic [2:0]  rep0;
    logic [19:0] off1;
    logic [1:0]  len1;
    logic [2:0]  rep1;
    logic [20:0] line;
    logic [15:0] found0;
    logic [15:0] end_found;
  } bundle_t;

endpackage

// ----- hdl/mss_front.sv -----
module mss_front #(
  parameter longint unsigned MAX_BYTES = mss_pkg::MAX_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_source_byte,
  input  logic            in_last_byte,
  input  logic            q_full,
  input  logic [15:0]     max_sites,
  output logic            in_ready,
  output logic            push,
  output mss_pkg::bundle_t bundle
);
  import mss_pkg::*;

  localparam int OFF_W = (MAX_BYTES > 2) ? $clog2(MAX_BYTES) : 1;
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(MAX_BYTES - 1);

  localparam logic [2:0] M_NORMAL     = 3'd0;
  localparam logic [2:0] M_LINE       = 3'd1;
  localparam logic [2:0] M_BLOCK      = 3'd2;
  localparam logic [2:0] M_BLOCK_STAR = 3'd3;
  localparam logic [2:0] M_STR        = 3'd4;
  localparam logic [2:0] M_STR_ESC    = 3'd5;
  localparam logic [2:0] M_CHR        = 3'd6;
  localparam logic [2:0] M_CHR_ESC    = 3'd7;

  localparam logic [2:0] P_NONE  = 3'd0;
  localparam logic [2:0] P_SLASH = 3'd1;
  localparam logic [2:0] P_LT    = 3'd2;
  localparam logic [2:0] P_GT    = 3'd3;
  localparam logic [2:0] P_EQ    = 3'd4;
  localparam logic [2:0] P_BANG  = 3'd5;
  localparam logic [2:0] P_AMP   = 3'd6;
  localparam logic [2:0] P_BAR   = 3'd7;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  logic [2:0]       mode_r, mode_nxt;
  logic [2:0]       pend_r, pend_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [20:0]      line_r, line_nxt;
  logic [15:0]      cnt_r, cnt_nxt;

  logic             accept;
  logic [7:0]       c;
  logic             last;
  logic [OFF_W-1:0] prev;
  logic             try0, try1, ok0, ok1, do_fresh, line_inc;
  logic [1:0]       len0;
  logic [2:0]       rep0, rep1;
  logic [15:0]      cnt_a;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign c        = in_source_byte;
  assign last     = in_last_byte;
  assign prev     = (off_r == '0) ? OFF_LAST : off_r - OFF_W'(1);

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    try0     = 1'b0;
    try1     = 1'b0;
    len0     = 2'd1;
    rep0     = REP_LE;
    rep1     = REP_LE;
    do_fresh = 1'b0;
    line_inc = 1'b0;
    case (mode_r)
      M_NORMAL: begin
        pend_nxt = P_NONE;
        do_fresh = 1'b1;
        case (pend_r)
          P_SLASH: begin
            if (c == CH_SLASH) begin
              mode_nxt = M_LINE;
              do_fresh = 1'b0;
            end else if (c == CH_STAR) begin
              mode_nxt = M_BLOCK;
              do_fresh = 1'b0;
            end
          end
          P_LT: begin
            if (c == CH_LT) begin
              do_fresh = 1'b0;              // shift, skipped
            end else if (c == CH_EQ) begin
              try0 = 1'b1; len0 = 2'd2; rep0 = REP_LT; do_fresh = 1'b0;
            end else begin
              try0 = 1'b1; rep0 = REP_LE;
            end
          end
          P_GT: begin
            if (c == CH_GT) begin
              do_fresh = 1'b0;
            end else if (c == CH_EQ) begin
              try0 = 1'b1; len0 = 2'd2; rep0 = REP_GT; do_fresh = 1'b0;
            end else begin
              try0 = 1'b1; rep0 = REP_GE;
            end
          end
          P_EQ: begin
            if (c == CH_EQ) begin
              try0 = 1'b1; len0 = 2'd2; rep0 = REP_NE; do_fresh = 1'b0;
            end
          end
          P_BANG: begin
            if (c == CH_EQ) begin
              try0 = 1'b1; len0 = 2'd2; rep0 = REP_EQ; do_fresh = 1'b0;
            end
          end
          P_AMP: begin
            if (c == CH_AMP) begin
              try0 = 1'b1; len0 = 2'd2; rep0 = REP_OR; do_fresh = 1'b0;
            end
          end
          P_BAR: begin
            if (c == CH_BAR) begin
              try0 = 1'b1; len0 = 2'd2; rep0 = REP_AND; do_fresh = 1'b0;
            end
          end
          default: ;
        endcase
        if (do_fresh) begin
          case (c)
            CH_NL:    line_inc = 1'b1;
            CH_DQ:    mode_nxt = M_STR;
            CH_SQ:    mode_nxt = M_CHR;
            CH_SLASH: if (!last) pend_nxt = P_SLASH;
            CH_LT: begin
              if (last) begin
                try1 = 1'b1; rep1 = REP_LE;
              end else begin
                pend_nxt = P_LT;
              end
            end
            CH_GT: begin
              if (last) begin
                try1 = 1'b1; rep1 = REP_GE;
              end else begin
                pend_nxt = P_GT;
              end
            end
            CH_EQ:   if (!last) pend_nxt = P_EQ;
            CH_BANG: if (!last) pend_nxt = P_BANG;
            CH_AMP:  if (!last) pend_nxt = P_AMP;
            CH_BAR:  if (!last) pend_nxt = P_BAR;
            default: ;
          endcase
        end
      end
      M_LINE: begin
        if (c == CH_NL) begin
          line_inc = 1'b1;
          mode_nxt = M_NORMAL;
        end
      end
      M_BLOCK: begin
        if (c == CH_STAR) mode_nxt = M_BLOCK_STAR;
        else if (c == CH_NL) line_inc = 1'b1;
      end
      M_BLOCK_STAR: begin
        if (c == CH_SLASH) begin
          mode_nxt = M_NORMAL;
        end else if (c == CH_NL) begin
          line_inc = 1'b1;
          mode_nxt = M_BLOCK;
        end else if (c != CH_STAR) begin
          mode_nxt = M_BLOCK;
        end
      end
      M_STR: begin
        if (c == CH_DQ) mode_nxt = M_NORMAL;
        else if (c == CH_BSL) mode_nxt = M_STR_ESC;
        else if (c == CH_NL) line_inc = 1'b1;
      end
      M_STR_ESC: begin
        if (c == CH_NL) line_inc = 1'b1;
        mode_nxt = M_STR;
      end
      M_CHR: begin
        // newlines inside char literals are not counted
        if (c == CH_SQ) mode_nxt = M_NORMAL;
        else if (c == CH_BSL) mode_nxt = M_CHR_ESC;
      end
      default: mode_nxt = M_CHR;
    endcase
  end

  // site limit, applied in order
  assign ok0   = try0 && (cnt_r < max_sites);
  assign cnt_a = cnt_r + 16'(ok0);
  assign ok1   = try1 && (cnt_a < max_sites);

  always_comb begin
    cnt_nxt  = cnt_a + 16'(ok1);
    line_nxt = (line_inc && line_r != LINE_MAX) ? line_r + 21'd1 : line_r;
    off_nxt  = (off_r == OFF_LAST) ? '0 : off_r + OFF_W'(1);

    bundle.n_sites   = 2'(ok0) + 2'(ok1);
    bundle.has_end   = last;
    bundle.line      = line_r;
    bundle.found0    = cnt_r + 16'd1;
    bundle.end_found = cnt_nxt;
    bundle.off1      = 20'(off_r);
    bundle.len1      = 2'd1;
    bundle.rep1      = rep1;
    if (ok0) begin
      bundle.off0 = 20'(prev);
      bundle.len0 = len0;
      bundle.rep0 = rep0;
    end else begin
      bundle.off0 = 20'(off_r);
      bundle.len0 = 2'd1;
      bundle.rep0 = rep1;
    end
  end

  assign push = accept && (ok0 || ok1 || last);

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      mode_r <= M_NORMAL;
      pend_r <= P_NONE;
      off_r  <= '0;
      line_r <= 21'd1;
      cnt_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      off_r  <= off_nxt;
      line_r <= line_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/mss_queue.sv -----
module mss_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mss_pkg::bundle_t din,
  input  logic             pop,
  output mss_pkg::bundle_t dout,
  output logic             full,
  output logic             empty
);
  import mss_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

  bundle_t          mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (cnt_r == CNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1)) : wr_r;
    rd_nxt  = do_pop  ? ((rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1)) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= din;
  end

endmodule

// ----- hdl/mss_back.sv -----
module mss_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mss_pkg::bundle_t head,
  input  logic             empty,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             out_result_kind,
  output logic [19:0]      out_site_offset,
  output logic [1:0]       out_site_length,
  output logic [2:0]       out_replacement,
  output logic [20:0]      out_site_line,
  output logic [15:0]      out_sites_found,
  output logic             out_last_result
);
  import mss_pkg::*;

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r;
  logic        load, is_last;
  logic [1:0]  total;

  logic        kind_nxt;
  logic [19:0] off_nxt;
  logic [1:0]  len_nxt;
  logic [2:0]  rep_nxt;
  logic [20:0] line_nxt;
  logic [15:0] found_nxt;

  logic        kind_r;
  logic [19:0] off_r;
  logic [1:0]  len_r;
  logic [2:0]  rep_r;
  logic [20:0] line_r;
  logic [15:0] found_r;
  logic        last_r;

  assign load    = !empty && (!valid_r || out_ready);
  assign total   = head.n_sites + 2'(head.has_end);
  assign is_last = (idx_r == total - 2'd1);
  assign pop     = load && is_last;
  assign idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;

  // pick one record of the head word
  always_comb begin
    kind_nxt  = KIND_SITE;
    off_nxt   = head.off0;
    len_nxt   = head.len0;
    rep_nxt   = head.rep0;
    line_nxt  = head.line;
    found_nxt = head.found0;
    if (idx_r >= head.n_sites) begin
      kind_nxt  = KIND_END;
      off_nxt   = '0;
      len_nxt   = '0;
      rep_nxt   = '0;
      line_nxt  = '0;
      found_nxt = head.end_found;
    end else if (idx_r == 2'd1) begin
      off_nxt   = head.off1;
      len_nxt   = head.len1;
      rep_nxt   = head.rep1;
      found_nxt = head.found0 + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_nxt;
      off_r   <= off_nxt;
      len_r   <= len_nxt;
      rep_r   <= rep_nxt;
      line_r  <= line_nxt;
      found_r <= found_nxt;
      last_r  <= is_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_result_kind = kind_r;
  assign out_site_offset = off_r;
  assign out_site_length = len_r;
  assign out_replacement = rep_r;
  assign out_site_line   = line_r;
  assign out_sites_found = found_r;
  assign out_last_result = last_r;

endmodule

// ----- hdl/mutation_site_scanner.sv -----
// Scans C source for mutable operator sites. One byte is accepted per cycle;
// the scanner state (comment/literal mode, pending first character, offset,
// line and site count) is updated in that same cycle, and the records a byte
// causes are written as one word into a four-entry queue. The output
// sequencer drains that queue one record per cycle while out_ready is high,
// through a registered output, so a final byte with two sites yields three
// records; the queue absorbs such bursts and output stalls, and input ready
// drops only while it is full. No clearing pass follows reset; max_sites
// resets to 65535.
module mutation_site_scanner #(
  parameter longint unsigned MAX_BYTES = mss_pkg::MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [19:0] out_site_offset,
  output logic [1:0]  out_site_length,
  output logic [2:0]  out_replacement,
  output logic [20:0] out_site_line,
  output logic [15:0] out_sites_found,
  output logic        out_last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_sites
);
  import mss_pkg::*;

  logic [15:0] max_sites_r;
  logic        push, pop, q_full, q_empty;
  bundle_t     q_din, q_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sites_r <= MAX_SITES_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_sites_r <= cfg_max_sites;
    end
  end

  mss_front #(.MAX_BYTES(MAX_BYTES)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_source_byte (in_source_byte),
    .in_last_byte   (in_last_byte),
    .q_full         (q_full),
    .max_sites      (max_sites_r),
    .in_ready       (in_ready),
    .push           (push),
    .bundle         (q_din)
  );

  mss_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .pop   (pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  mss_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_dout),
    .empty           (q_empty),
    .pop             (pop),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_site_offset (out_site_offset),
    .out_site_length (out_site_length),
    .out_replacement (out_replacement),
    .out_site_line   (out_site_line),
    .out_sites_found (out_sites_found),
    .out_last_result (out_last_result)
  );

endmodule

// ----- hdl/mss_checker.sv -----
module mss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [19:0] out_site_offset,
  input logic [1:0]  out_site_length,
  input logic [2:0]  out_replacement,
  input logic [20:0] out_site_line,
  input logic [15:0] out_sites_found,
  input logic        out_last_result
);
  import mss_pkg::*;

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_site_offset)
      && $stable(out_result_kind) && $stable(out_sites_found))
    else $error("result word changed while stalled");

  // end record closes the byte's results
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_END |-> out_last_result)
    else $error("end record not marked last");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_END |->
      out_site_offset == 20'd0 && out_site_length == 2'd0
      && out_replacement == 3'd0 && out_site_line == 21'd0)
    else $error("end record carries site fields");

  a_site_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_SITE |->
      out_site_length != 2'd0 && out_site_line != 21'd0
      && out_sites_found != 16'd0)
    else $error("malformed site record");

endmodule

bind mutation_site_scanner mss_checker u_mss_checker (.*);
